FILE: rtl/rpn_stack_evaluator_top_macros.svh
// Assertion helpers for the RPN evaluator.
`ifndef RPN_STACK_EVALUATOR_TOP_MACROS_SVH
`define RPN_STACK_EVALUATOR_TOP_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define RPN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rpn evaluator check failed");

// Next-cycle implication.
`define RPN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rpn evaluator check failed");

`endif

FILE: rtl/rpn_pkg.sv
package rpn_pkg;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_ADD     = 3'd1,
    OP_SUB     = 3'd2,
    OP_MUL     = 3'd3,
    OP_DIV     = 3'd4,
    OP_PRINT   = 3'd5,
    OP_UNKNOWN = 3'd6,
    OP_RSVD    = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_PRINT   = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_ZDIV    = 3'd4,
    ST_UNKNOWN = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_MUL,
    S_DIV,
    S_SAT,
    S_DONE
  } state_e;

  localparam int unsigned DataW = 32;
  localparam int unsigned DivW  = 48;

  // Control from the sequencer to every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  function automatic logic [DataW-1:0] sat64(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    begin
      hi = 64'sh0000_0000_7FFF_FFFF;
      lo = -64'sh0000_0000_8000_0000;
      if (v > hi) begin
        sat64 = 32'h7FFF_FFFF;
      end else if (v < lo) begin
        sat64 = 32'h8000_0000;
      end else begin
        sat64 = v[31:0];
      end
    end
  endfunction

endpackage

FILE: rtl/rpn_stack_evaluator_top.sv
// RPN stack evaluator. Tokens come in on start/op_i/operand_value_i and
// are taken when busy is low; every request yields exactly one result,
// shown for a single cycle with done_o high. There is no backpressure: the
// receiver must take each result in the cycle done_o is high. The value stack
// is a row of STACK_DEPTH cells that all shift together, top in cell 0. A new
// request is taken only after the previous one has shown its result. No
// clearing pass is needed after reset; only the fill count is reset.
// Values are signed Q16.16; all arithmetic saturates to 32 bits.
`include "rpn_stack_evaluator_top_macros.svh"

module rpn_stack_evaluator_top #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op_i,
  input  logic signed [31:0] operand_value_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic signed [31:0] result_value_o
);
  localparam int unsigned CountW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW     = rpn_pkg::DataW;

  rpn_pkg::state_e state_q, state_d;
  rpn_pkg::op_e    op_q, op_d;
  logic [CountW-1:0] count_q, count_d;
  logic [2:0]      status_q, status_d;
  logic [DW-1:0]   a_q, a_d, b_q, b_d;
  logic [DW-1:0]   res_q, res_d;
  logic [DW-1:0]   shown_q, shown_d;
  logic [1:0]      pops_q, pops_d;
  logic signed [63:0] prod_q, prod_d;
  logic            qneg_q, qneg_d;

  // Stack row.
  rpn_pkg::cell_ctl_t cell_ctl;
  logic [DW-1:0]      push_word;
  logic [DW-1:0]      cell_val [STACK_DEPTH];
  logic [DW-1:0]      top_word;

  for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
    logic [DW-1:0] below_w;
    logic [DW-1:0] above_w;
    if (g == 0) begin : g_first
      assign below_w = push_word;
    end else begin : g_mid
      assign below_w = cell_val[g-1];
    end
    if (g == STACK_DEPTH - 1) begin : g_last
      assign above_w = cell_val[g];
    end else begin : g_up
      assign above_w = cell_val[g+1];
    end
    rpn_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (cell_ctl),
      .below_i (below_w),
      .above_i (above_w),
      .value_o (cell_val[g])
    );
  end

  assign top_word = cell_val[0];

  // Divider on magnitudes. The dividend is taken from the second pop as it
  // happens, since the divider loads in that same cycle.
  logic                       div_start;
  logic                       div_done;
  logic [rpn_pkg::DivW-1:0]   div_num;
  logic [DW-1:0]              div_den;
  logic [rpn_pkg::DivW-1:0]   div_quot;
  logic [DW-1:0]              abs_a, abs_b;

  assign abs_a   = a_d[DW-1] ? (~a_d + 1'b1) : a_d;
  assign abs_b   = b_q[DW-1] ? (~b_q + 1'b1) : b_q;
  assign div_num = {abs_a, 16'h0000};
  assign div_den = abs_b;

  rpn_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  function automatic rpn_pkg::op_e rpn_rpn_op(input logic [2:0] code);
    rpn_rpn_op = rpn_pkg::op_e'(code);
  endfunction

  logic accept;
  assign accept = start && !busy;

  logic signed [63:0] rounded;
  logic signed [63:0] quot_s;
  logic signed [63:0] sum_s;
  assign rounded = (prod_q + 64'sd32768) >>> 16;
  assign quot_s  = qneg_q ? -$signed({16'h0000, div_quot}) : $signed({16'h0000, div_quot});
  assign sum_s   = (op_q == rpn_pkg::OP_ADD)
                 ? ($signed({{32{a_q[DW-1]}}, a_q}) + $signed({{32{b_q[DW-1]}}, b_q}))
                 : ($signed({{32{a_q[DW-1]}}, a_q}) - $signed({{32{b_q[DW-1]}}, b_q}));

  // Next state and datapath.
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    count_d  = count_q;
    status_d = status_q;
    a_d      = a_q;
    b_d      = b_q;
    res_d    = res_q;
    shown_d  = shown_q;
    pops_d   = pops_q;
    prod_d   = prod_q;
    qneg_d   = qneg_q;
    unique case (state_q)
      rpn_pkg::S_IDLE: begin
        if (accept) begin
          op_d     = rpn_rpn_op(op_i);
          status_d = rpn_pkg::ST_OK;
          shown_d  = '0;
          pops_d   = 2'd0;
          unique case (rpn_rpn_op(op_i))
            rpn_pkg::OP_PUSH: begin
              if (count_q < CountW'(STACK_DEPTH)) begin
                count_d = count_q + 1'b1;
              end else begin
                status_d = rpn_pkg::ST_FULL;
              end
              state_d = rpn_pkg::S_DONE;
            end
            rpn_pkg::OP_UNKNOWN, rpn_pkg::OP_RSVD: begin
              status_d = rpn_pkg::ST_UNKNOWN;
              state_d  = rpn_pkg::S_DONE;
            end
            default: state_d = rpn_pkg::S_POP;
          endcase
        end
      end
      rpn_pkg::S_POP: begin
        // One pop per cycle: first the top (b), then the second (a).
        logic [DW-1:0] v;
        v = (count_q != '0) ? top_word : '0;
        if (count_q != '0) begin
          count_d = count_q - 1'b1;
        end else if (status_q == rpn_pkg::ST_OK) begin
          status_d = rpn_pkg::ST_EMPTY;
        end
        if (op_q == rpn_pkg::OP_PRINT) begin
          if (count_q != '0) begin
            status_d = rpn_pkg::ST_PRINT;
            shown_d  = v;
          end
          state_d = rpn_pkg::S_DONE;
        end else if (pops_q == 2'd0) begin
          b_d    = v;
          pops_d = 2'd1;
          if (op_q == rpn_pkg::OP_DIV && v == '0) begin
            if (status_d == rpn_pkg::ST_OK) begin
              status_d = rpn_pkg::ST_ZDIV;
            end
            state_d = rpn_pkg::S_DONE;
          end
        end else begin
          a_d = v;
          unique case (op_q)
            rpn_pkg::OP_MUL: state_d = rpn_pkg::S_MUL;
            rpn_pkg::OP_DIV: state_d = rpn_pkg::S_DIV;
            default:         state_d = rpn_pkg::S_SAT;
          endcase
        end
      end
      rpn_pkg::S_MUL: begin
        prod_d  = $signed(a_q) * $signed(b_q);
        state_d = rpn_pkg::S_SAT;
      end
      rpn_pkg::S_DIV: begin
        qneg_d = a_q[DW-1] ^ b_q[DW-1];
        if (div_done) begin
          state_d = rpn_pkg::S_SAT;
        end
      end
      rpn_pkg::S_SAT: begin
        // Pop freed a slot, so the push always fits.
        unique case (op_q)
          rpn_pkg::OP_MUL: res_d = rpn_pkg::sat64(rounded);
          rpn_pkg::OP_DIV: res_d = rpn_pkg::sat64(quot_s);
          default:         res_d = rpn_pkg::sat64(sum_s);
        endcase
        count_d = count_q + 1'b1;
        state_d = rpn_pkg::S_DONE;
      end
      rpn_pkg::S_DONE: state_d = rpn_pkg::S_IDLE;
      default: state_d = rpn_pkg::S_IDLE;
    endcase
  end

  // Outputs and stack control.
  always_comb begin
    cell_ctl  = '0;
    push_word = operand_value_i;
    div_start = 1'b0;
    unique case (state_q)
      rpn_pkg::S_IDLE: begin
        cell_ctl.push = accept && (rpn_rpn_op(op_i) == rpn_pkg::OP_PUSH)
                        && (count_q < CountW'(STACK_DEPTH));
      end
      rpn_pkg::S_POP: cell_ctl.pop = (count_q != '0);
      rpn_pkg::S_SAT: begin
        cell_ctl.push = 1'b1;
        push_word     = res_d;
      end
      default: cell_ctl = '0;
    endcase
    if (state_q == rpn_pkg::S_POP && state_d == rpn_pkg::S_DIV) begin
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpn_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    status_q <= status_d;
    a_q      <= a_d;
    b_q      <= b_d;
    res_q    <= res_d;
    shown_q  <= shown_d;
    pops_q   <= pops_d;
    prod_q   <= prod_d;
    qneg_q   <= qneg_d;
  end

  assign busy           = (state_q != rpn_pkg::S_IDLE);
  assign done_o         = (state_q == rpn_pkg::S_DONE);
  assign status_o       = status_q;
  assign result_value_o = shown_q;

  `RPN_ASSERT_IMP(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CountW'(STACK_DEPTH))
  `RPN_ASSERT_NXT(a_done_one, clk_i, rst_ni, done_o, !done_o)
  `RPN_ASSERT_IMP(a_shown_print, clk_i, rst_ni, done_o && status_o != rpn_pkg::ST_PRINT,
                  result_value_o == '0)
endmodule

FILE: rtl/rpn_cell.sv
// One stack slot: takes the word above on pop, the word below on push.
module rpn_cell (
  input  logic                       clk_i,
  input  rpn_pkg::cell_ctl_t         ctl_i,
  input  logic [rpn_pkg::DataW-1:0]  below_i,
  input  logic [rpn_pkg::DataW-1:0]  above_i,
  output logic [rpn_pkg::DataW-1:0]  value_o
);
  logic [rpn_pkg::DataW-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (ctl_i.push) begin
      value_d = below_i;
    end else if (ctl_i.pop) begin
      value_d = above_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
endmodule

FILE: rtl/rpn_divider.sv
// Radix-2 restoring divider on magnitudes, one quotient bit a cycle.
module rpn_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rpn_pkg::DivW-1:0]     num_i,
  input  logic [rpn_pkg::DataW-1:0]    den_i,
  output logic                         done_o,
  output logic [rpn_pkg::DivW-1:0]     quot_o
);
  localparam int unsigned CntW = $clog2(rpn_pkg::DivW + 1);

  logic [rpn_pkg::DivW-1:0]  quot_q, quot_d;
  logic [rpn_pkg::DataW:0]   rem_q, rem_d;
  logic [rpn_pkg::DataW-1:0] den_q, den_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic [rpn_pkg::DataW:0]   trial;
  logic [rpn_pkg::DataW:0]   shifted;

  always_comb begin
    quot_d  = quot_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    shifted = {rem_q[rpn_pkg::DataW-1:0], quot_q[rpn_pkg::DivW-1]};
    trial   = shifted - {1'b0, den_q};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(rpn_pkg::DivW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[rpn_pkg::DataW]) begin
        rem_d = trial;
        quot_d = {quot_q[rpn_pkg::DivW-2:0], 1'b1};
      end else begin
        rem_d = shifted;
        quot_d = {quot_q[rpn_pkg::DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quot_o = quot_q;
endmodule

FILE: sim/rpn_stack_evaluator_top_test.sv
module rpn_stack_evaluator_top_test;

  localparam int unsigned Depth = 128;
  // Cycles with no request accepted and no result shown before giving up.
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned NumRandom = 800;

  typedef struct packed {
    logic [2:0] op;
    logic signed [31:0] value;
  } token_t;

  typedef struct packed {
    rpn_pkg::status_e status;
    logic signed [31:0] value;
  } outcome_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic [2:0] op_i;
  logic signed [31:0] operand_value_i;
  logic done_o;
  logic [2:0] status_o;
  logic signed [31:0] result_value_o;

  rpn_stack_evaluator_top #(.STACK_DEPTH(Depth)) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .op_i(op_i),
    .operand_value_i(operand_value_i),
    .done_o(done_o),
    .status_o(status_o),
    .result_value_o(result_value_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  token_t   token_q[$];
  outcome_t outcome_q[$];
  logic signed [31:0] model_stack[Depth];
  int unsigned model_count;
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_printed;
  int unsigned n_special;
  int unsigned idle_cycles;
  bit stim_done;

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sh0_7FFF_FFFF) begin
      clamp32 = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      clamp32 = 32'sh8000_0000;
    end else begin
      clamp32 = v[31:0];
    end
  endfunction

  // Golden stack: each request updates the shadow stack and returns its result.
  function automatic outcome_t eval_token(input token_t t);
    outcome_t r;
    logic signed [31:0] top_v;
    logic signed [31:0] sec_v;
    logic signed [65:0] wide;
    r.status = rpn_pkg::ST_OK;
    r.value = '0;
    top_v = '0;
    sec_v = '0;
    if (t.op inside {rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV,
                     rpn_pkg::OP_PRINT}) begin
      // first pop (divisor / right operand / printed value)
      if (model_count > 0) begin
        model_count--;
        top_v = model_stack[model_count];
      end else begin
        r.status = rpn_pkg::ST_EMPTY;
      end
    end
    case (t.op)
      rpn_pkg::OP_PUSH: begin
        if (model_count < Depth) begin
          model_stack[model_count] = t.value;
          model_count++;
        end else begin
          r.status = rpn_pkg::ST_FULL;
        end
      end
      rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
        if (t.op == rpn_pkg::OP_DIV && top_v == 0) begin
          // zero divisor: dividend stays, nothing pushed
          if (r.status == rpn_pkg::ST_OK) r.status = rpn_pkg::ST_ZDIV;
        end else begin
          if (model_count > 0) begin
            model_count--;
            sec_v = model_stack[model_count];
          end else if (r.status == rpn_pkg::ST_OK) begin
            r.status = rpn_pkg::ST_EMPTY;
          end
          case (t.op)
            rpn_pkg::OP_ADD: wide = 66'(sec_v) + 66'(top_v);
            rpn_pkg::OP_SUB: wide = 66'(sec_v) - 66'(top_v);
            // arithmetic shift floors, giving round-half-up
            rpn_pkg::OP_MUL: wide = (66'(sec_v) * 66'(top_v) + 66'sd32768) >>> 16;
            default: wide = (66'(sec_v) <<< 16) / 66'(top_v);
          endcase
          // after two pops there is always room for the push
          model_stack[model_count] = clamp32(wide);
          model_count++;
        end
      end
      rpn_pkg::OP_PRINT: begin
        if (r.status == rpn_pkg::ST_OK) begin
          r.status = rpn_pkg::ST_PRINT;
          r.value = top_v;
        end
      end
      default: r.status = rpn_pkg::ST_UNKNOWN;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: rand_value = 32'sh7FFF_FFFF - $urandom_range(0, 3);
      1: rand_value = 32'sh8000_0000 + $urandom_range(0, 3);
      2: rand_value = $signed($urandom_range(0, 8)) - 4;
      3: rand_value = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      default: rand_value = $urandom();
    endcase
  endfunction

  function automatic logic [2:0] rand_op();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) rand_op = rpn_pkg::OP_PUSH;
    else if (pick < 48) rand_op = rpn_pkg::OP_ADD;
    else if (pick < 56) rand_op = rpn_pkg::OP_SUB;
    else if (pick < 66) rand_op = rpn_pkg::OP_MUL;
    else if (pick < 76) rand_op = rpn_pkg::OP_DIV;
    else if (pick < 94) rand_op = rpn_pkg::OP_PRINT;
    else if (pick < 97) rand_op = rpn_pkg::OP_UNKNOWN;
    else rand_op = rpn_pkg::OP_RSVD;
  endfunction

  task automatic add_token(input logic [2:0] op, input logic signed [31:0] v);
    token_t t;
    t.op = op;
    t.value = v;
    token_q.push_back(t);
  endtask

  // Stimulus: directed corner cases, then random, with a fill/drain burst
  // now and then to reach the full-stack case.
  initial begin
    int unsigned k;
    add_token(rpn_pkg::OP_PRINT, 0);                     // print on empty stack
    add_token(rpn_pkg::OP_ADD, 32'sd5);                  // both pops empty
    add_token(rpn_pkg::OP_DIV, 0);                       // empty divisor pop
    add_token(rpn_pkg::OP_PUSH, 32'sh7FFF_FFFF);
    add_token(rpn_pkg::OP_PUSH, 32'sh7FFF_FFFF);
    add_token(rpn_pkg::OP_ADD, 0);                       // positive overflow
    add_token(rpn_pkg::OP_PUSH, 32'sh8000_0000);
    add_token(rpn_pkg::OP_SUB, 0);                       // positive overflow
    add_token(rpn_pkg::OP_PRINT, 0);
    add_token(rpn_pkg::OP_PUSH, 32'sh0001_8000);
    add_token(rpn_pkg::OP_PUSH, -32'sh0002_0000);
    add_token(rpn_pkg::OP_MUL, 0);
    add_token(rpn_pkg::OP_PUSH, 32'sh0000_0001);
    add_token(rpn_pkg::OP_MUL, 0);                       // multiply by the smallest positive value
    add_token(rpn_pkg::OP_PUSH, 0);
    add_token(rpn_pkg::OP_DIV, 0);                       // zero divisor
    add_token(rpn_pkg::OP_PUSH, 32'sh0003_0000);
    add_token(rpn_pkg::OP_DIV, 0);
    add_token(rpn_pkg::OP_PRINT, 0);
    add_token(rpn_pkg::OP_PUSH, 32'sh8000_0000);
    add_token(rpn_pkg::OP_PUSH, -32'sh0000_0001);
    add_token(rpn_pkg::OP_DIV, 0);                       // quotient overflow
    add_token(rpn_pkg::OP_UNKNOWN, 32'sh1234_5678);
    add_token(rpn_pkg::OP_RSVD, -32'sd1);
    add_token(rpn_pkg::OP_PRINT, 0);
    k = 0;
    while (k < NumRandom) begin
      if ($urandom_range(0, 199) == 0) begin
        // overfill, then drain with prints
        repeat (Depth + 3) add_token(rpn_pkg::OP_PUSH, rand_value());
        repeat (Depth + 2) add_token(rpn_pkg::OP_PRINT, 0);
        k += 2 * Depth + 5;
      end else begin
        add_token(rand_op(), rand_value());
        k++;
      end
    end
    stim_done = 1'b1;
  end

  // Driver: changes inputs on the falling edge, one request per handshake.
  initial begin
    start = 1'b0;
    op_i = '0;
    operand_value_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  int unsigned gap_cnt;
  bit took_q;

  // Handshake seen at the rising edge, acted on at the next falling edge.
  always @(posedge clk_i) begin
    took_q <= rst_ni && start && !busy;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (took_q) begin
        outcome_q.push_back(eval_token(token_q.pop_front()));
        n_sent++;
        gap_cnt = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        start <= 1'b0;
      end else if (!start) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (token_q.size() > 0) begin
          start <= 1'b1;
          op_i <= token_q[0].op;
          operand_value_i <= token_q[0].value;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest expected one.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        $error("unexpected result status=%0d value=%0d", status_o, result_value_o);
        n_errors++;
      end else begin
        want = outcome_q.pop_front();
        n_checked++;
        if (want.status == rpn_pkg::ST_PRINT) n_printed++;
        if (want.status inside {rpn_pkg::ST_FULL, rpn_pkg::ST_EMPTY, rpn_pkg::ST_ZDIV}) begin
          n_special++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status_o);
          n_errors++;
        end
        if (result_value_o !== want.value) begin
          $error("result_value: expected %0d, actual %0d", want.value, result_value_o);
          n_errors++;
        end
      end
    end
  end

  // Watchdog and end of run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout with %0d results outstanding", outcome_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_printed = 0;
    n_special = 0;
    idle_cycles = 0;
    gap_cnt = 0;
    model_count = 0;
    wait (stim_done && token_q.size() == 0 && !start);
    wait (outcome_q.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("sent %0d requests, checked %0d results", n_sent, n_checked);
    $display("%0d prints, %0d full/empty/zero-divisor cases", n_printed, n_special);
    if (n_errors == 0 && outcome_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
